// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the pixel format converter.
// Depends on nothing; simulation builds get the checks, synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== rtl/pfc_pkg.sv =====
// Package of the pixel format converter: payload types, format codes,
// layout table and channel resize helpers. Depends on nothing.
package pfc_pkg;

    // palette store geometry
    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_IDX_W = (PALETTE_ENTRIES > 2) ? $clog2(PALETTE_ENTRIES) : 1;

    // depth of the queue between front and back, and of the result buffer
    localparam int MID_DEPTH = 2;
    localparam int MID_PTR_W = $clog2(MID_DEPTH);
    localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);

    // pixel format codes
    localparam logic [4:0] FMT_A8          = 5'd0;
    localparam logic [4:0] FMT_RGB555      = 5'd1;
    localparam logic [4:0] FMT_RGB565      = 5'd3;
    localparam logic [4:0] FMT_RGB888      = 5'd5;
    localparam logic [4:0] FMT_RGBA8888    = 5'd11;
    localparam logic [4:0] FMT_LAST_DIRECT = 5'd12;
    localparam logic [4:0] FMT_PAL_555     = 5'd13;
    localparam logic [4:0] FMT_PAL_565     = 5'd14;
    localparam logic [4:0] FMT_PAL_888     = 5'd15;
    localparam logic [4:0] FMT_PAL_8888    = 5'd16;

    localparam logic [4:0] FMT_RESET = FMT_RGBA8888;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_FORMAT   = 2'd1;

    // operation codes
    localparam logic OP_CONVERT = 1'b0;
    localparam logic OP_PALETTE = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [31:0] pixel_in;
        logic [7:0]  palette_slot;
        logic [31:0] palette_word;
    } in_t;

    typedef struct packed {
        logic [31:0] pixel_out;
        logic [2:0]  byte_count;
        logic        format_error;
    } out_t;

    // classified item passed from front to back
    typedef struct packed {
        logic [31:0] word;
        logic [3:0]  base;
        logic        src_bad;
    } mid_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic [3:0] cb;
        logic [3:0] gb;
        logic [3:0] ab;
        logic [4:0] sg;
        logic [4:0] s2;
        logic [4:0] sa;
        logic       swap;
        logic [2:0] bytes;
    } layout_t;

    // layout of a non-paletted format
    function automatic layout_t layout(input logic [3:0] code);
        layout_t l;
        case (code)
            4'd0:    l = '{4'd8, 4'd8, 4'd0, 5'd0, 5'd0,  5'd0,  1'b0, 3'd1};
            4'd1:    l = '{4'd5, 4'd5, 4'd0, 5'd5, 5'd10, 5'd0,  1'b0, 3'd2};
            4'd2:    l = '{4'd5, 4'd5, 4'd0, 5'd5, 5'd10, 5'd0,  1'b1, 3'd2};
            4'd3:    l = '{4'd5, 4'd6, 4'd0, 5'd5, 5'd11, 5'd0,  1'b0, 3'd2};
            4'd4:    l = '{4'd5, 4'd6, 4'd0, 5'd5, 5'd11, 5'd0,  1'b1, 3'd2};
            4'd5:    l = '{4'd8, 4'd8, 4'd0, 5'd8, 5'd16, 5'd0,  1'b0, 3'd3};
            4'd6:    l = '{4'd8, 4'd8, 4'd0, 5'd8, 5'd16, 5'd0,  1'b1, 3'd3};
            4'd7:    l = '{4'd4, 4'd4, 4'd4, 5'd4, 5'd8,  5'd12, 1'b0, 3'd2};
            4'd8:    l = '{4'd4, 4'd4, 4'd4, 5'd4, 5'd8,  5'd12, 1'b1, 3'd2};
            4'd9:    l = '{4'd5, 4'd5, 4'd1, 5'd5, 5'd10, 5'd15, 1'b0, 3'd2};
            4'd10:   l = '{4'd5, 4'd5, 4'd1, 5'd5, 5'd10, 5'd15, 1'b1, 3'd2};
            4'd11:   l = '{4'd8, 4'd8, 4'd8, 5'd8, 5'd16, 5'd24, 1'b0, 3'd4};
            4'd12:   l = '{4'd8, 4'd8, 4'd8, 5'd8, 5'd16, 5'd24, 1'b1, 3'd4};
            default: l = '{4'd8, 4'd8, 4'd0, 5'd0, 5'd0,  5'd0,  1'b0, 3'd1};
        endcase
        return l;
    endfunction

    // low n bits set, n up to 8
    function automatic logic [7:0] mask8(input logic [3:0] n);
        logic [8:0] t;
        t = (n >= 4'd8) ? 9'h0FF : ((9'd1 << n) - 9'd1);
        return t[7:0];
    endfunction

    // widen or narrow a channel of at most 8 bits
    function automatic logic [7:0] resize(input logic [7:0] v, input logic [3:0] from,
                                          input logic [3:0] to);
        logic [7:0] r;
        if (from == to)
            r = v;
        else if (from == 4'd1)
            r = (v != 8'd0) ? mask8(to) : 8'd0;
        else if (from == 4'd6 && to == 4'd8)
            r = (v >> 1) << 3;
        else if (to < from)
            r = v >> (from - to);
        else
            r = v << (to - from);
        return r;
    endfunction

endpackage

// ===== rtl/pixel_format_converter_top.sv =====
// Pixel format converter top level: one pixel in and one result out per clock while pop keeps up.
// A pixel beat passes the front stage register, the queue and the result buffer, in that order.
// Throughput: one beat per cycle unless the 2-entry queues fill up and raise full.
// Palette beats write the palette RAM and give no result.
// Reset (rst_n low, asynchronous) empties both queues and sets both formats to RGBA8888;
// palette contents are undefined until written.
`include "assert_macros.svh"

module pixel_format_converter_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  pfc_pkg::in_t                       item,
    output logic                               empty,
    input  logic                               pop,
    output pfc_pkg::out_t                      result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pfc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [4:0]                         cfg_data
);

    logic [4:0]        source_format_reg;
    logic [4:0]        dest_format_reg;
    logic              accept;
    logic              front_valid;
    logic              mid_wr;
    logic              mid_rd;
    pfc_pkg::mid_t     front_item;
    pfc_pkg::mid_t     queue_item;
    pfc_pkg::q_stat_t  mid_stat;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_format_reg <= pfc_pkg::FMT_RESET;
            dest_format_reg   <= pfc_pkg::FMT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pfc_pkg::CFG_SOURCE_FORMAT: source_format_reg <= cfg_data;
                pfc_pkg::CFG_DEST_FORMAT:   dest_format_reg   <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // input handshake: stall only when the front stage cannot drain
    assign full   = front_valid && mid_stat.full;
    assign accept = push && !full;
    assign mid_wr = front_valid && !mid_stat.full;

    pfc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .item          (item),
        .source_format (source_format_reg),
        .take          (mid_wr),
        .mid_valid     (front_valid),
        .mid           (front_item)
    );

    pfc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (mid_wr),
        .wr_item (front_item),
        .rd      (mid_rd),
        .rd_item (queue_item),
        .stat    (mid_stat)
    );

    pfc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .mid         (queue_item),
        .mid_stat    (mid_stat),
        .mid_rd      (mid_rd),
        .dest_format (dest_format_reg),
        .pop         (pop),
        .empty       (empty),
        .result      (result)
    );

    // checks
    `ASSERT_PROP(a_pixel_enters_front, clk, rst_n, push && !full && item.operation == pfc_pkg::OP_CONVERT |=> front_valid, "pixel beat did not reach front stage")
    `ASSERT_PROP(a_palette_no_result, clk, rst_n, push && !full && item.operation == pfc_pkg::OP_PALETTE && !front_valid |=> !front_valid, "palette beat produced a pixel item")
    `ASSERT_PROP(a_error_payload, clk, rst_n, !empty && result.format_error |-> result.pixel_out == 32'd0 && result.byte_count == 3'd1, "format error result carries data")
    `ASSERT_NEVER(a_byte_count_range, clk, rst_n, !empty && (result.byte_count == 3'd0 || result.byte_count > 3'd4), "byte count out of range")

endmodule

// ===== rtl/pfc_front.sv =====
// Front end of the pixel format converter: takes input beats, owns the
// palette store, classifies the source format. Depends on pfc_pkg.
module pfc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  pfc_pkg::in_t    item,
    input  logic [4:0]      source_format,
    input  logic            take,
    output logic            mid_valid,
    output pfc_pkg::mid_t   mid
);

    logic [31:0] pal_mem [pfc_pkg::PALETTE_ENTRIES];

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] pixel_reg;
    logic [31:0] rd_data_reg;
    logic        idx_ok_reg;
    logic        slot_ok;
    logic        idx_ok;

    assign slot_ok = {1'b0, item.palette_slot} < 9'(pfc_pkg::PALETTE_ENTRIES);
    assign idx_ok  = {1'b0, item.pixel_in[7:0]} < 9'(pfc_pkg::PALETTE_ENTRIES);

    // palette write on a palette beat, read on a pixel beat
    always_ff @(posedge clk)
    begin
        if (accept && item.operation == pfc_pkg::OP_PALETTE && slot_ok)
            pal_mem[item.palette_slot[pfc_pkg::PAL_IDX_W-1:0]] <= item.palette_word;
        if (accept && item.operation == pfc_pkg::OP_CONVERT)
            rd_data_reg <= pal_mem[item.pixel_in[pfc_pkg::PAL_IDX_W-1:0]];
    end

    // pixel payload
    always_ff @(posedge clk)
    begin
        if (accept && item.operation == pfc_pkg::OP_CONVERT)
        begin
            pixel_reg  <= item.pixel_in;
            idx_ok_reg <= idx_ok;
        end
    end

    // stage valid: pixel beats only, palette beats end here
    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b0;
        if (accept && item.operation == pfc_pkg::OP_CONVERT)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // classify: direct formats pass the pixel, paletted ones the entry, unknown codes are flagged bad
    always_comb
    begin
        mid.word    = pixel_reg;
        mid.base    = source_format[3:0];
        mid.src_bad = 1'b0;
        if (source_format > pfc_pkg::FMT_LAST_DIRECT)
        begin
            mid.word = idx_ok_reg ? rd_data_reg : 32'd0;
            case (source_format)
                pfc_pkg::FMT_PAL_555:  mid.base = pfc_pkg::FMT_RGB555[3:0];
                pfc_pkg::FMT_PAL_565:  mid.base = pfc_pkg::FMT_RGB565[3:0];
                pfc_pkg::FMT_PAL_888:  mid.base = pfc_pkg::FMT_RGB888[3:0];
                pfc_pkg::FMT_PAL_8888: mid.base = pfc_pkg::FMT_RGBA8888[3:0];
                default:
                begin
                    mid.base    = pfc_pkg::FMT_A8[3:0];
                    mid.src_bad = 1'b1;
                end
            endcase
        end
    end

    assign mid_valid = valid_reg;

endmodule

// ===== rtl/pfc_queue.sv =====
// Short queue of classified items between front and back end.
// Depends on pfc_pkg.
module pfc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  pfc_pkg::mid_t     wr_item,
    input  logic              rd,
    output pfc_pkg::mid_t     rd_item,
    output pfc_pkg::q_stat_t  stat
);

    pfc_pkg::mid_t                   mem_reg [pfc_pkg::MID_DEPTH];
    logic [pfc_pkg::MID_PTR_W-1:0]   wr_ptr_reg;
    logic [pfc_pkg::MID_PTR_W-1:0]   rd_ptr_reg;
    logic [pfc_pkg::MID_CNT_W-1:0]   count_reg;
    logic [pfc_pkg::MID_CNT_W-1:0]   count_next;
    logic                            do_wr;
    logic                            do_rd;

    assign stat.full  = count_reg == pfc_pkg::MID_CNT_W'(pfc_pkg::MID_DEPTH);
    assign stat.empty = count_reg == '0;
    assign do_wr      = wr && !stat.full;
    assign do_rd      = rd && !stat.empty;
    assign rd_item    = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_item;
    end

    always_comb
    begin
        count_next = count_reg;
        case ({do_wr, do_rd})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/pfc_back.sv =====
// Back end of the pixel format converter: unpacks channels, converts,
// repacks and buffers results for the output side. Depends on pfc_pkg.
module pfc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  pfc_pkg::mid_t     mid,
    input  pfc_pkg::q_stat_t  mid_stat,
    output logic              mid_rd,
    input  logic [4:0]        dest_format,
    input  logic              pop,
    output logic              empty,
    output pfc_pkg::out_t     result
);

    // floor(s/3) for s below 768 by reciprocal multiply
    function automatic logic [7:0] div3(input logic [9:0] s);
        logic [20:0] p;
        p = 21'(s) * 21'd683;
        return p[18:11];
    endfunction

    pfc_pkg::layout_t sl;
    pfc_pkg::layout_t dl;
    logic [7:0]       r, g, b, a, c0, c2, lum, q3;
    logic [3:0]       cb, gb, ab;
    logic [9:0]       sum;
    logic [7:0]       rr, gg, bb, aa;
    logic [31:0]      packed_px;
    pfc_pkg::out_t    conv;

    // channel unpack
    always_comb
    begin
        sl  = pfc_pkg::layout(mid.base);
        c0  = mid.word[7:0] & pfc_pkg::mask8(sl.cb);
        c2  = 8'(mid.word >> sl.s2) & pfc_pkg::mask8(sl.cb);
        r   = sl.swap ? c2 : c0;
        b   = sl.swap ? c0 : c2;
        g   = 8'(mid.word >> sl.sg) & pfc_pkg::mask8(sl.gb);
        cb  = sl.cb;
        gb  = sl.gb;
        a   = 8'hFF;
        ab  = 4'd8;
        sum = 10'd0;
        q3  = 8'd0;
        lum = 8'd0;
        if (mid.base == pfc_pkg::FMT_A8[3:0])
        begin
            // gray source feeds all three channels, opaque
            r   = mid.word[7:0];
            g   = mid.word[7:0];
            b   = mid.word[7:0];
            lum = mid.word[7:0];
            cb  = 4'd8;
            gb  = 4'd8;
        end
        else if (sl.ab != 4'd0)
        begin
            ab  = sl.ab;
            a   = 8'(mid.word >> sl.sa) & pfc_pkg::mask8(sl.ab);
            lum = pfc_pkg::resize(a, sl.ab, 4'd8);
        end
        else
        begin
            // gray is the channel average, 5-bit sources use 5-bit green
            if (cb == 4'd8)
                sum = 10'(r) + 10'(g) + 10'(b);
            else
                sum = 10'(r) + 10'(pfc_pkg::resize(g, gb, 4'd5)) + 10'(b);
            q3  = div3(sum);
            lum = (cb == 4'd8) ? q3 : (q3 << 3);
        end
    end

    // repack into the destination layout
    always_comb
    begin
        dl = pfc_pkg::layout(dest_format[3:0]);
        rr = pfc_pkg::resize(r, cb, dl.cb);
        gg = pfc_pkg::resize(g, gb, dl.gb);
        bb = pfc_pkg::resize(b, cb, dl.cb);
        aa = (dl.ab != 4'd0) ? pfc_pkg::resize(a, ab, dl.ab) : 8'd0;
        packed_px = 32'(dl.swap ? bb : rr) | (32'(gg) << dl.sg)
                  | (32'(dl.swap ? rr : bb) << dl.s2) | (32'(aa) << dl.sa);
        if (dest_format == pfc_pkg::FMT_A8)
            packed_px = {24'd0, lum};

        conv.pixel_out    = packed_px;
        conv.byte_count   = dl.bytes;
        conv.format_error = 1'b0;
        if (dest_format > pfc_pkg::FMT_LAST_DIRECT)
        begin
            conv.pixel_out    = 32'd0;
            conv.byte_count   = 3'd1;
            conv.format_error = 1'b1;
        end
        else if (mid.src_bad)
            conv.pixel_out = 32'd0;
    end

    // result buffer, head drives the output ports
    pfc_pkg::out_t                   ob_mem_reg [pfc_pkg::MID_DEPTH];
    logic [pfc_pkg::MID_PTR_W-1:0]   ob_wr_ptr_reg;
    logic [pfc_pkg::MID_PTR_W-1:0]   ob_rd_ptr_reg;
    logic [pfc_pkg::MID_CNT_W-1:0]   ob_count_reg;
    logic [pfc_pkg::MID_CNT_W-1:0]   ob_count_next;
    logic                            ob_full;
    logic                            do_pop;

    assign ob_full = ob_count_reg == pfc_pkg::MID_CNT_W'(pfc_pkg::MID_DEPTH);
    assign empty   = ob_count_reg == '0;
    assign do_pop  = pop && !empty;
    assign mid_rd  = !mid_stat.empty && !ob_full;
    assign result  = ob_mem_reg[ob_rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (mid_rd)
            ob_mem_reg[ob_wr_ptr_reg] <= conv;
    end

    always_comb
    begin
        ob_count_next = ob_count_reg;
        case ({mid_rd, do_pop})
            2'b10:   ob_count_next = ob_count_reg + 1'b1;
            2'b01:   ob_count_next = ob_count_reg - 1'b1;
            default: ob_count_next = ob_count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_wr_ptr_reg <= '0;
            ob_rd_ptr_reg <= '0;
            ob_count_reg  <= '0;
        end
        else
        begin
            if (mid_rd)
                ob_wr_ptr_reg <= ob_wr_ptr_reg + 1'b1;
            if (do_pop)
                ob_rd_ptr_reg <= ob_rd_ptr_reg + 1'b1;
            ob_count_reg <= ob_count_next;
        end
    end

endmodule

// ===== tb/pfc_checker.sv =====
// Scoreboard for the pixel format converter: watches the item, result and config channels.
// Predicts each converted pixel from its own format and palette copies and compares results.
// Depends on pfc_pkg for the payload structs, operation codes and register indexes.
module pfc_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic                          full,
    input  pfc_pkg::in_t                  item,
    input  logic                          empty,
    input  logic                          pop,
    input  pfc_pkg::out_t                 result,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [pfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [4:0]                    cfg_data,
    output int unsigned                   pending,
    output int unsigned                   mismatches
);
    import pfc_pkg::*;

    // all format codes, in code order
    typedef enum logic [4:0] {
        PF_A8, PF_RGB555, PF_BGR555, PF_RGB565, PF_BGR565, PF_RGB888, PF_BGR888,
        PF_RGBA4444, PF_BGRA4444, PF_RGBA5551, PF_BGRA5551, PF_RGBA8888, PF_BGRA8888,
        PF_PAL_555, PF_PAL_565, PF_PAL_888, PF_PAL_8888
    } pix_fmt_t;

    // channel widths and positions of a direct format
    typedef struct packed {
        logic [3:0] cbits;
        logic [3:0] gbits;
        logic [3:0] abits;
        logic [4:0] gshift;
        logic [4:0] tshift;
        logic [4:0] ashift;
        logic       blue_low;
        logic [2:0] nbytes;
    } fmt_geom_t;

    logic [4:0]  src_fmt;
    logic [4:0]  dst_fmt;
    logic [31:0] palette_mem [PALETTE_ENTRIES];
    out_t        expected_q [$];

    function automatic fmt_geom_t geom_of(input logic [4:0] code);
        fmt_geom_t g;
        case (code)
            PF_RGB555:   g = '{4'd5, 4'd5, 4'd0, 5'd5, 5'd10, 5'd0,  1'b0, 3'd2};
            PF_BGR555:   g = '{4'd5, 4'd5, 4'd0, 5'd5, 5'd10, 5'd0,  1'b1, 3'd2};
            PF_RGB565:   g = '{4'd5, 4'd6, 4'd0, 5'd5, 5'd11, 5'd0,  1'b0, 3'd2};
            PF_BGR565:   g = '{4'd5, 4'd6, 4'd0, 5'd5, 5'd11, 5'd0,  1'b1, 3'd2};
            PF_RGB888:   g = '{4'd8, 4'd8, 4'd0, 5'd8, 5'd16, 5'd0,  1'b0, 3'd3};
            PF_BGR888:   g = '{4'd8, 4'd8, 4'd0, 5'd8, 5'd16, 5'd0,  1'b1, 3'd3};
            PF_RGBA4444: g = '{4'd4, 4'd4, 4'd4, 5'd4, 5'd8,  5'd12, 1'b0, 3'd2};
            PF_BGRA4444: g = '{4'd4, 4'd4, 4'd4, 5'd4, 5'd8,  5'd12, 1'b1, 3'd2};
            PF_RGBA5551: g = '{4'd5, 4'd5, 4'd1, 5'd5, 5'd10, 5'd15, 1'b0, 3'd2};
            PF_BGRA5551: g = '{4'd5, 4'd5, 4'd1, 5'd5, 5'd10, 5'd15, 1'b1, 3'd2};
            PF_RGBA8888: g = '{4'd8, 4'd8, 4'd8, 5'd8, 5'd16, 5'd24, 1'b0, 3'd4};
            PF_BGRA8888: g = '{4'd8, 4'd8, 4'd8, 5'd8, 5'd16, 5'd24, 1'b1, 3'd4};
            default:     g = '{4'd8, 4'd8, 4'd0, 5'd0, 5'd0,  5'd0,  1'b0, 3'd1};
        endcase
        return g;
    endfunction

    function automatic int unsigned bit_mask(input int unsigned n);
        return (32'd1 << n) - 32'd1;
    endfunction

    // narrow by dropping low bits, widen by shifting; 1-bit alpha widens to all ones
    function automatic int unsigned scale_chan(input int unsigned v, input int unsigned from,
                                               input int unsigned to);
        if (from == to)
            return v;
        if (from == 1)
            return (v != 0) ? bit_mask(to) : 0;
        if (from == 6 && to == 8)
            return (v >> 1) << 3;
        if (to < from)
            return v >> (from - to);
        return v << (to - from);
    endfunction

    function automatic out_t convert_pixel(input logic [31:0] pix);
        out_t        o;
        fmt_geom_t   sgeo;
        fmt_geom_t   dgeo;
        logic [4:0]  base;
        int unsigned word, r, g, b, a, cb, gb, ab, lum, res, c0, c2;
        o = '0;
        // invalid destination: zero pixel, one byte, error
        if (dst_fmt > PF_BGRA8888)
        begin
            o.byte_count   = 3'd1;
            o.format_error = 1'b1;
            return o;
        end
        dgeo = geom_of(dst_fmt);
        o.byte_count = dgeo.nbytes;

        // fetch the source word, through the palette for paletted formats
        if (src_fmt <= PF_BGRA8888)
        begin
            word = pix;
            base = src_fmt;
        end
        else if (src_fmt <= PF_PAL_8888)
        begin
            word = palette_mem[pix[7:0]];
            case (src_fmt)
                PF_PAL_555: base = PF_RGB555;
                PF_PAL_565: base = PF_RGB565;
                PF_PAL_888: base = PF_RGB888;
                default:    base = PF_RGBA8888;
            endcase
        end
        else
            return o;

        // unpack channels; gray source feeds all three, alpha opaque
        if (base == PF_A8)
        begin
            r   = word & 32'hFF;
            g   = r;
            b   = r;
            lum = r;
            cb  = 8;
            gb  = 8;
            a   = 32'hFF;
            ab  = 8;
        end
        else
        begin
            sgeo = geom_of(base);
            cb   = sgeo.cbits;
            gb   = sgeo.gbits;
            c0   = word & bit_mask(cb);
            c2   = (word >> sgeo.tshift) & bit_mask(cb);
            g    = (word >> sgeo.gshift) & bit_mask(gb);
            r    = sgeo.blue_low ? c2 : c0;
            b    = sgeo.blue_low ? c0 : c2;
            if (sgeo.abits != 0)
            begin
                ab  = sgeo.abits;
                a   = (word >> sgeo.ashift) & bit_mask(ab);
                lum = scale_chan(a, ab, 8);
            end
            else
            begin
                a  = 32'hFF;
                ab = 8;
                if (cb == 8)
                    lum = (r + g + b) / 3;
                else
                    lum = ((r + scale_chan(g, gb, 5) + b) / 3) << 3;
            end
        end

        // pack into the destination
        if (dst_fmt == PF_A8)
            res = lum & 32'hFF;
        else
        begin
            c0  = scale_chan(r, cb, dgeo.cbits);
            c2  = scale_chan(b, cb, dgeo.cbits);
            g   = scale_chan(g, gb, dgeo.gbits);
            res = (dgeo.blue_low ? c2 : c0) | (g << dgeo.gshift)
                | ((dgeo.blue_low ? c0 : c2) << dgeo.tshift);
            if (dgeo.abits != 0)
                res = res | (scale_chan(a, ab, dgeo.abits) << dgeo.ashift);
        end
        o.pixel_out = res;
        return o;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] result check: %s", $time, msg);
        mismatches = mismatches + 1;
    endtask

    // monitor: result beat first, then config and item beats of the same edge
    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            src_fmt = FMT_RESET;
            dst_fmt = FMT_RESET;
            expected_q.delete();
            mismatches = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_q.size() == 0)
                    report_mismatch($sformatf("unexpected result %h", result));
                else
                begin
                    want = expected_q.pop_front();
                    if (result.pixel_out !== want.pixel_out)
                        report_mismatch($sformatf("pixel_out %h, expected %h",
                                                  result.pixel_out, want.pixel_out));
                    if (result.byte_count !== want.byte_count)
                        report_mismatch($sformatf("byte_count %0d, expected %0d",
                                                  result.byte_count, want.byte_count));
                    if (result.format_error !== want.format_error)
                        report_mismatch($sformatf("format_error %b, expected %b",
                                                  result.format_error, want.format_error));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SOURCE_FORMAT)
                    src_fmt = cfg_data;
                else if (cfg_index == CFG_DEST_FORMAT)
                    dst_fmt = cfg_data;
            end
            if (push && !full)
            begin
                if (item.operation == OP_PALETTE)
                    palette_mem[item.palette_slot] = item.palette_word;
                else
                    expected_q.push_back(convert_pixel(item.pixel_in));
            end
        end
        pending = expected_q.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for pixel_format_converter_top: clock, reset, stimulus and verdict.
// Directed pixels and palette writes first, then random phases over many format pairs.
// Depends on pfc_pkg, the converter RTL and the pfc_checker scoreboard.
module tb_top;
    import pfc_pkg::*;

    localparam int         MAX_GAP         = 17;
    localparam int         LONG_STALL      = 100;
    localparam int         SETTLE          = 8;
    localparam int         PHASES          = 104;
    localparam int         ITEMS_PER_PHASE = 12;
    localparam int         NUM_SRC         = FMT_PAL_8888 + 1;
    localparam logic [4:0] FMT_BAD_SRC     = FMT_PAL_8888 + 5'd1;
    localparam logic [4:0] FMT_CODE_MAX    = 5'd31;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 push      = 1'b0;
    logic                 full;
    in_t                  item      = '0;
    logic                 empty;
    logic                 pop       = 1'b0;
    out_t                 result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SOURCE_FORMAT;
    logic [4:0]           cfg_data  = '0;
    int unsigned          pending;
    int unsigned          mismatches;

    // shared between the sender and the receiver
    bit                   no_idle        = 1'b0;
    int unsigned          stall_requests = 0;

    // palette slots written so far; paletted sources only read these
    bit                   pal_written [PALETTE_ENTRIES];
    logic [7:0]           written_slots [$];

    pixel_format_converter_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pfc_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .mismatches (mismatches)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic in_t make_item(input logic op, input logic [31:0] pix,
                                      input logic [7:0] slot, input logic [31:0] word);
        in_t it;
        it.operation    = op;
        it.pixel_in     = pix;
        it.palette_slot = slot;
        it.palette_word = word;
        return it;
    endfunction

    function automatic logic [31:0] rand_word();
        logic [7:0] b;
        b = 8'($urandom);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return {4{b}};
            default: return $urandom;
        endcase
    endfunction

    function automatic in_t rand_item(input bit pal_src);
        in_t it;
        it.operation    = ($urandom_range(0, 99) < 15) ? OP_PALETTE : OP_CONVERT;
        it.pixel_in     = rand_word();
        it.palette_slot = 8'($urandom);
        it.palette_word = rand_word();
        if (it.operation == OP_CONVERT && pal_src)
            it.pixel_in[7:0] = written_slots[$urandom_range(0, written_slots.size() - 1)];
        return it;
    endfunction

    // offer one item beat; entered and left at a falling edge, push left high
    task automatic push_item(input in_t it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
        if (it.operation == OP_PALETTE && !pal_written[it.palette_slot])
        begin
            pal_written[it.palette_slot] = 1'b1;
            written_slots.push_back(it.palette_slot);
        end
        @(negedge clk);
    endtask

    // stop offering, wait for all results, then let trailing palette beats retire
    task automatic drain();
        push <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // write both format registers back to back while the block is idle
    task automatic write_formats(input logic [4:0] src, input logic [4:0] dst);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SOURCE_FORMAT;
        cfg_data  <= src;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_index <= CFG_DEST_FORMAT;
        cfg_data  <= dst;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // sweep every source, then every destination, then edge codes, then random pairs
    task automatic choose_formats(input int p, output logic [4:0] src, output logic [4:0] dst);
        if (p < NUM_SRC)
        begin
            src = 5'(p);
            dst = 5'($urandom_range(FMT_A8, FMT_LAST_DIRECT));
        end
        else if (p < 2 * NUM_SRC)
        begin
            src = 5'($urandom_range(FMT_A8, FMT_PAL_8888));
            dst = 5'(p - NUM_SRC);
        end
        else
        begin
            case (p - 2 * NUM_SRC)
                0:
                begin
                    src = FMT_CODE_MAX;
                    dst = 5'($urandom_range(FMT_A8, FMT_LAST_DIRECT));
                end
                1:
                begin
                    src = FMT_BAD_SRC;
                    dst = FMT_CODE_MAX;
                end
                2:
                begin
                    src = FMT_PAL_8888;
                    dst = FMT_LAST_DIRECT;
                end
                3:
                begin
                    src = FMT_A8;
                    dst = FMT_A8;
                end
                4:
                begin
                    src = FMT_CODE_MAX;
                    dst = FMT_CODE_MAX;
                end
                default:
                begin
                    src = ($urandom_range(0, 7) == 0) ? 5'($urandom)
                        : 5'($urandom_range(FMT_A8, FMT_PAL_8888));
                    dst = ($urandom_range(0, 7) == 0) ? 5'($urandom)
                        : 5'($urandom_range(FMT_A8, FMT_LAST_DIRECT));
                end
            endcase
        end
    endtask

    // result side: random pop gaps, plus long hold-offs on request
    initial
    begin
        int idle;
        int unsigned stalls_served;
        stalls_served = 0;
        @(posedge rst_n);
        forever
        begin
            idle = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stalls_served != stall_requests)
            begin
                idle = idle + LONG_STALL;
                stalls_served = stalls_served + 1;
            end
            if (idle > 0)
            begin
                pop <= 1'b0;
                repeat (idle) @(negedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            @(negedge clk);
        end
    end

    // hard stop if the run hangs
    initial
    begin
        #3000000;
        $display("** pixel_format_converter_top: FAILED **");
        $finish;
    end

    initial
    begin
        logic [4:0] src;
        logic [4:0] dst;
        bit         pal_src;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset formats: RGBA8888 straight through, extreme words
        push_item(make_item(OP_CONVERT, 32'h0000_0000, 8'h00, 32'h0000_0000));
        push_item(make_item(OP_CONVERT, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF));
        push_item(make_item(OP_CONVERT, 32'h8080_8080, 8'h80, 32'h8080_8080));
        push_item(make_item(OP_CONVERT, 32'h7F7F_7F7F, 8'h7F, 32'h7F7F_7F7F));

        // palette writes at both ends of the store
        push_item(make_item(OP_PALETTE, 32'hFFFF_FFFF, 8'h00, 32'h0000_0000));
        push_item(make_item(OP_PALETTE, 32'h0000_0000, 8'hFF, 32'hFFFF_FFFF));
        push_item(make_item(OP_PALETTE, 32'h1234_5678, 8'h80, 32'h80FF_7F01));
        push_item(make_item(OP_PALETTE, 32'h0000_0000, 8'h01, 32'h0000_F81F));

        // paletted 8888 to gray: gray follows alpha; index ignores upper bits
        write_formats(FMT_PAL_8888, FMT_A8);
        push_item(make_item(OP_CONVERT, 32'hFFFF_FF80, 8'h00, 32'h0000_0000));
        push_item(make_item(OP_CONVERT, 32'hFFFF_FF00, 8'h00, 32'h0000_0000));
        push_item(make_item(OP_CONVERT, 32'h0000_00FF, 8'h00, 32'h0000_0000));

        // paletted 565 entry
        write_formats(FMT_PAL_565, FMT_RGB888);
        push_item(make_item(OP_CONVERT, 32'h0000_0001, 8'h00, 32'h0000_0000));

        // 565 green widening drops its low bit first
        write_formats(FMT_RGB565, FMT_RGB888);
        push_item(make_item(OP_CONVERT, 32'h0000_07E0, 8'h00, 32'h0000_0000));
        push_item(make_item(OP_CONVERT, 32'hFFFF_FFFF, 8'h00, 32'h0000_0000));
        push_item(make_item(OP_CONVERT, 32'h0000_0020, 8'h00, 32'h0000_0000));

        // gray source expands to r = g = b, opaque
        write_formats(FMT_A8, FMT_RGBA8888);
        push_item(make_item(OP_CONVERT, 32'hFFFF_FF00, 8'h00, 32'h0000_0000));
        push_item(make_item(OP_CONVERT, 32'h0000_00FF, 8'h00, 32'h0000_0000));

        // gray output as channel average
        write_formats(FMT_RGB888, FMT_A8);
        push_item(make_item(OP_CONVERT, 32'h00FF_FFFE, 8'h00, 32'h0000_0000));

        // bad source code, then bad destination code
        write_formats(FMT_BAD_SRC, FMT_LAST_DIRECT);
        push_item(make_item(OP_CONVERT, 32'hDEAD_BEEF, 8'h00, 32'h0000_0000));
        write_formats(FMT_RGB555, FMT_CODE_MAX);
        push_item(make_item(OP_CONVERT, 32'h0000_7FFF, 8'h00, 32'h0000_0000));

        // random phases; a few run with no idling, two hold the result side off
        for (int p = 0; p < PHASES; p++)
        begin
            choose_formats(p, src, dst);
            write_formats(src, dst);
            pal_src = (src >= FMT_PAL_555) && (src <= FMT_PAL_8888);
            no_idle = (p % 5 == 2) || (p == 5) || (p == 60);
            if (p == 5 || p == 60)
                stall_requests = stall_requests + 1;
            repeat (ITEMS_PER_PHASE) push_item(rand_item(pal_src));
        end

        drain();
        if (mismatches == 0 && pending == 0)
            $display("** pixel_format_converter_top: PASSED **");
        else
            $display("** pixel_format_converter_top: FAILED **");
        $finish;
    end

endmodule
